// ===== rtl/prq_pkg.sv =====
package prq_pkg;

  localparam int unsigned NumPortsDef = 16;
  localparam int unsigned TrafficW    = 32;
  localparam int unsigned MetricW     = 8;
  localparam int unsigned QbitsW      = 4;
  localparam int unsigned KeepW       = 16;
  localparam int unsigned CfgIdxW     = 2;

  localparam logic [QbitsW-1:0] QbitsMin = 4'd1;
  localparam logic [QbitsW-1:0] QbitsMax = 4'd8;

  localparam logic [CfgIdxW-1:0] CfgQbits     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCeScale   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDecayKeep = 2'd2;

  localparam logic [QbitsW-1:0]   QbitsRst     = 4'd3;
  localparam logic [TrafficW-1:0] CeScaleRst   = 32'd4295;
  localparam logic [KeepW-1:0]    DecayKeepRst = 16'd52429;

  typedef struct packed {
    logic rd_port;
    logic add_wr;
    logic mul;
    logic walk_clr;
    logic tick_wr;
    logic idle_clr;
    logic out_pkt;
    logic out_fin;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic port_ok;
    logic walk_last;
  } sts_t;

endpackage

// ===== rtl/port_rate_estimator_quantizer_core.sv =====
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_stall_o  | mode, port, payload_bytes, header_bytes
// out     | output    | out_valid_o/out_stall_i | traffic, metric, all_idle
// cfg     | input     | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
// A packet request passes through these steps before the next one can be accepted:
// port memory read, saturating add and write-back, metric multiply, quantize.
// A decay tick walks one port per cycle.
// Reset clears the valid bits of the port memory at once, so every port reads zero.
// The input is stalled until the controller is idle again. A finished result waits while
// the output register holds an unaccepted one.
module port_rate_estimator_quantizer_core
  import prq_pkg::*;
#(
  parameter int unsigned NUM_PORTS = NumPortsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [TrafficW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                in_mode_i,
  input  logic [3:0]          in_port_i,
  input  logic [15:0]         in_payload_bytes_i,
  input  logic [5:0]          in_header_bytes_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [TrafficW-1:0] out_traffic_o,
  output logic [MetricW-1:0]  out_metric_o,
  output logic                out_all_idle_o
);

  cmd_t cmd;
  sts_t sts;

  prq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  prq_datapath #(
    .NUM_PORTS (NUM_PORTS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_mode_i          (in_mode_i),
    .in_port_i          (in_port_i),
    .in_payload_bytes_i (in_payload_bytes_i),
    .in_header_bytes_i  (in_header_bytes_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_traffic_o      (out_traffic_o),
    .out_metric_o       (out_metric_o),
    .out_all_idle_o     (out_all_idle_o)
  );

endmodule

// ===== rtl/prq_ctrl.sv =====
module prq_ctrl
  import prq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ADD  = 6'b000010,
    S_MUL  = 6'b000100,
    S_QNT  = 6'b001000,
    S_TICK = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.mode) begin
            cmd_o.walk_clr = 1'b1;
            state_d        = S_TICK;
          end else if (sts_i.port_ok) begin
            cmd_o.rd_port = 1'b1;
            state_d       = S_ADD;
          end else begin
            cmd_o.idle_clr = 1'b1;
            state_d        = S_FIN;
          end
        end
      end
      S_ADD: begin
        cmd_o.add_wr = 1'b1;
        state_d      = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_QNT;
      end
      S_QNT: begin
        if (out_free) begin
          cmd_o.out_pkt = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_TICK: begin
        cmd_o.tick_wr = 1'b1;
        if (sts_i.walk_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.out_fin = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_pkt || cmd_o.out_fin) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_pkt || cmd_o.out_fin) |-> out_free)
    else $error("result loaded over a waiting result");

  a_rise_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_QNT || state_q == S_FIN))
    else $error("result appeared without a finishing step");

  a_walk_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TICK && sts_i.walk_last) |=> (state_q == S_FIN))
    else $error("decay walk did not finish after the last port");

  a_pkt_path : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !sts_i.mode && sts_i.port_ok) |=> (state_q == S_ADD))
    else $error("valid packet did not start its update");

endmodule

// ===== rtl/prq_datapath.sv =====
module prq_datapath
  import prq_pkg::*;
#(
  parameter int unsigned NUM_PORTS = NumPortsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [TrafficW-1:0] cfg_wdata_i,
  input  logic                in_mode_i,
  input  logic [3:0]          in_port_i,
  input  logic [15:0]         in_payload_bytes_i,
  input  logic [5:0]          in_header_bytes_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic [TrafficW-1:0] out_traffic_o,
  output logic [MetricW-1:0]  out_metric_o,
  output logic                out_all_idle_o
);

  localparam int unsigned IdxW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_PORTS - 1);

  logic [QbitsW-1:0]   qbits_q;
  logic [TrafficW-1:0] ce_scale_q;
  logic [KeepW-1:0]    decay_keep_q;

  logic [TrafficW-1:0] mem_q [NUM_PORTS];
  logic [NUM_PORTS-1:0] vld_q;
  logic [TrafficW-1:0] rd_q;
  logic                rd_vld_q;
  logic [TrafficW-1:0] rd_eff;

  logic [IdxW-1:0]     port_q;
  logic [15:0]         payload_q;
  logic [5:0]          header_q;
  logic [IdxW-1:0]     walk_q;
  logic                idle_q;
  logic [TrafficW-1:0] t_q;
  logic [2*TrafficW-1:0] prod_q;
  logic [TrafficW-1:0] out_traffic_q;
  logic [MetricW-1:0]  out_metric_q;
  logic                out_all_idle_q;

  logic [31:0]         port_ext;
  logic [IdxW-1:0]     port_idx;
  logic [IdxW-1:0]     rd_addr;
  logic                rd_en;
  logic                wr_en;
  logic [IdxW-1:0]     wr_addr;
  logic [TrafficW-1:0] wr_data;
  logic [TrafficW:0]   sum;
  logic [TrafficW-1:0] sat;
  logic [TrafficW+KeepW-1:0] decay_prod;
  logic [TrafficW-1:0] decayed;
  logic [QbitsW-1:0]   q_eff;
  logic [5:0]          shamt;
  logic [2*TrafficW-1:0] lvl;
  logic [2*TrafficW-1:0] top;
  logic [MetricW-1:0]  metric;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qbits_q      <= QbitsRst;
      ce_scale_q   <= CeScaleRst;
      decay_keep_q <= DecayKeepRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgQbits:     qbits_q      <= cfg_wdata_i[QbitsW-1:0];
        CfgCeScale:   ce_scale_q   <= cfg_wdata_i;
        CfgDecayKeep: decay_keep_q <= cfg_wdata_i[KeepW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign port_ext      = 32'(in_port_i);
  assign port_idx      = port_ext[IdxW-1:0];
  assign sts_o.mode    = in_mode_i;
  assign sts_o.port_ok = (port_ext < 32'(NUM_PORTS));
  assign sts_o.walk_last = (walk_q == LastIdx);

  assign rd_en   = cmd_i.rd_port || cmd_i.walk_clr || cmd_i.tick_wr;
  assign rd_addr = cmd_i.rd_port  ? port_idx :
                   cmd_i.walk_clr ? '0 : IdxW'(walk_q + 1'b1);
  assign rd_eff  = rd_vld_q ? rd_q : '0;

  assign sum        = {1'b0, rd_eff} + (TrafficW+1)'(payload_q) + (TrafficW+1)'(header_q);
  assign sat        = sum[TrafficW] ? '1 : sum[TrafficW-1:0];
  assign decay_prod = rd_eff * decay_keep_q;
  assign decayed    = decay_prod[TrafficW+KeepW-1:KeepW];

  assign wr_en   = cmd_i.add_wr || cmd_i.tick_wr;
  assign wr_addr = cmd_i.add_wr ? port_q : walk_q;
  assign wr_data = cmd_i.add_wr ? sat : decayed;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_port) begin
      port_q    <= port_idx;
      payload_q <= in_payload_bytes_i;
      header_q  <= in_header_bytes_i;
    end
    if (cmd_i.add_wr) begin
      t_q <= sat;
    end
    if (cmd_i.mul) begin
      prod_q <= t_q * ce_scale_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q <= '0;
      idle_q <= 1'b0;
    end else begin
      if (cmd_i.walk_clr) begin
        walk_q <= '0;
        idle_q <= 1'b1;
      end else if (cmd_i.tick_wr) begin
        walk_q <= IdxW'(walk_q + 1'b1);
        if (decayed != '0) begin
          idle_q <= 1'b0;
        end
      end else if (cmd_i.idle_clr) begin
        idle_q <= 1'b0;
      end
    end
  end

  always_comb begin
    q_eff = qbits_q;
    if (qbits_q < QbitsMin) begin
      q_eff = QbitsMin;
    end else if (qbits_q > QbitsMax) begin
      q_eff = QbitsMax;
    end
  end

  assign shamt  = 6'd32 - 6'(q_eff);
  assign lvl    = prod_q >> shamt;
  assign top    = ((2*TrafficW)'(1) << q_eff) - (2*TrafficW)'(1);
  assign metric = (lvl > top) ? top[MetricW-1:0] : lvl[MetricW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_pkt) begin
      out_traffic_q  <= t_q;
      out_metric_q   <= metric;
      out_all_idle_q <= 1'b0;
    end else if (cmd_i.out_fin) begin
      out_traffic_q  <= '0;
      out_metric_q   <= '0;
      out_all_idle_q <= idle_q;
    end
  end

  assign out_traffic_o  = out_traffic_q;
  assign out_metric_o   = out_metric_q;
  assign out_all_idle_o = out_all_idle_q;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb
  import prq_pkg::*;
();

  localparam int unsigned NumPorts = NumPortsDef;
  localparam logic ModePacket = 1'b0;
  localparam logic ModeTick = 1'b1;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned SettleCycles = NumPorts + 6;
  localparam int unsigned FillPackets = 40;

  typedef struct packed {
    logic        mode;
    logic [3:0]  port;
    logic [15:0] payload;
    logic [5:0]  header;
  } rate_req_t;

  typedef struct packed {
    logic [TrafficW-1:0] traffic;
    logic [MetricW-1:0]  metric;
    logic                all_idle;
  } rate_res_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [TrafficW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                in_mode_i = 1'b0;
  logic [3:0]          in_port_i = '0;
  logic [15:0]         in_payload_bytes_i = '0;
  logic [5:0]          in_header_bytes_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [TrafficW-1:0] out_traffic_o;
  logic [MetricW-1:0]  out_metric_o;
  logic                out_all_idle_o;

  rate_req_t pending_reqs[$];
  rate_req_t req_in_flight;
  rate_res_t rate_expected[$];
  rate_res_t oldest_rate;

  logic [QbitsW-1:0]   shadow_qbits = QbitsRst;
  logic [TrafficW-1:0] shadow_scale = CeScaleRst;
  logic [KeepW-1:0]    shadow_keep = DecayKeepRst;
  logic [TrafficW-1:0] shadow_traffic [NumPorts];

  bit quiet = 1'b0;
  int unsigned errors = 0;
  int unsigned n_pkts = 0;
  int unsigned n_ticks = 0;
  int unsigned n_results = 0;
  int unsigned n_writes = 0;
  int unsigned stall_cycles = 0;

  port_rate_estimator_quantizer_core u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_mode_i          (in_mode_i),
    .in_port_i          (in_port_i),
    .in_payload_bytes_i (in_payload_bytes_i),
    .in_header_bytes_i  (in_header_bytes_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_traffic_o      (out_traffic_o),
    .out_metric_o       (out_metric_o),
    .out_all_idle_o     (out_all_idle_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void estimate_rate(input rate_req_t r);
    rate_res_t   res;
    logic [63:0] sum;
    logic [63:0] prod;
    logic [63:0] lvl;
    logic [63:0] top;
    logic [31:0] t;
    logic        idle;
    int unsigned q;
    int          i;
    res = '0;
    if (r.mode == ModeTick) begin
      idle = 1'b1;
      for (i = 0; i < NumPorts; i++) begin
        prod = ({32'd0, shadow_traffic[i]} * {48'd0, shadow_keep}) >> 16;
        shadow_traffic[i] = prod[31:0];
        if (shadow_traffic[i] != '0) idle = 1'b0;
      end
      res.all_idle = idle;
      n_ticks++;
    end else begin
      n_pkts++;
      if (r.port < NumPorts) begin
        sum = {32'd0, shadow_traffic[r.port]} + {48'd0, r.payload} + {58'd0, r.header};
        t = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        shadow_traffic[r.port] = t;
        q = 32'(shadow_qbits);
        if (q < QbitsMin) q = 32'(QbitsMin);
        if (q > QbitsMax) q = 32'(QbitsMax);
        prod = {32'd0, t} * {32'd0, shadow_scale};
        lvl = prod >> (32 - q);
        top = (64'd1 << q) - 64'd1;
        if (lvl > top) lvl = top;
        res.traffic = t;
        res.metric = lvl[MetricW-1:0];
      end
    end
    rate_expected = {rate_expected, res};
  endfunction

  function automatic void push_req(input logic mode, input logic [3:0] port,
                                   input logic [15:0] payload, input logic [5:0] header);
    rate_req_t r;
    r.mode = mode;
    r.port = port;
    r.payload = payload;
    r.header = header;
    pending_reqs = {pending_reqs, r};
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TrafficW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgQbits: begin
        shadow_qbits = val[QbitsW-1:0];
      end
      CfgCeScale: begin
        shadow_scale = val;
      end
      CfgDecayKeep: begin
        shadow_keep = val[KeepW-1:0];
      end
      default: begin
      end
    endcase
    n_writes++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || rate_expected.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        estimate_rate(req_in_flight);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_reqs.size() != 0 && (quiet || $urandom_range(99) >= 7)) begin
          req_in_flight = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          in_mode_i <= req_in_flight.mode;
          in_port_i <= req_in_flight.port;
          in_payload_bytes_i <= req_in_flight.payload;
          in_header_bytes_i <= req_in_flight.header;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (rate_expected.size() == 0) begin
          $display("%0t: result with none expected, traffic 0x%0h metric 0x%0h idle %0b",
                   $time, out_traffic_o, out_metric_o, out_all_idle_o);
          errors++;
        end else begin
          oldest_rate = rate_expected.pop_front();
          check_field("traffic", oldest_rate.traffic, out_traffic_o);
          check_field("metric", oldest_rate.metric, out_metric_o);
          check_field("all_idle", oldest_rate.all_idle, out_all_idle_o);
        end
      end
      out_stall_i <= !quiet && ($urandom_range(99) < 7);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))) begin
      stall_cycles <= 0;
    end else if (rst_ni) begin
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $time, stall_cycles);
        $display("[port_rate_estimator_quantizer_core] ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int          ph;
    int          k;
    logic [3:0]  rp;
    logic [15:0] rpay;
    logic [5:0]  rhdr;
    logic [31:0] rq;
    logic [31:0] rs;
    logic [31:0] rk;
    for (k = 0; k < NumPorts; k++) shadow_traffic[k] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_req(ModeTick, 4'd0, 16'd0, 6'd0);
    push_req(ModePacket, 4'd0, 16'd0, 6'd0);
    push_req(ModePacket, 4'd15, 16'hFFFF, 6'd63);
    push_req(ModePacket, 4'd15, 16'hFFFF, 6'd60);
    push_req(ModePacket, 4'd5, 16'h5555, 6'h15);
    push_req(ModePacket, 4'd10, 16'hAAAA, 6'h2A);
    push_req(ModeTick, 4'd15, 16'hFFFF, 6'h3F);
    push_req(ModeTick, 4'd0, 16'd0, 6'd0);
    drain();

    write_reg(CfgQbits, 32'd8);
    write_reg(CfgCeScale, 32'hFFFF_FFFF);
    write_reg(CfgDecayKeep, 32'h0000_FFFF);
    push_req(ModePacket, 4'd3, 16'd1, 6'd0);
    push_req(ModePacket, 4'd4, 16'd0, 6'd0);
    push_req(ModePacket, 4'd15, 16'hFFFF, 6'd63);
    push_req(ModeTick, 4'd0, 16'd0, 6'd0);
    drain();

    // Zero width, zero scale and zero keep: metric stays 0 and a tick empties all ports.
    write_reg(CfgQbits, 32'd0);
    write_reg(CfgCeScale, 32'd0);
    write_reg(CfgDecayKeep, 32'd0);
    push_req(ModePacket, 4'd7, 16'hFFFF, 6'd63);
    push_req(ModeTick, 4'd0, 16'd0, 6'd0);
    push_req(ModePacket, 4'd7, 16'd1, 6'd0);
    drain();

    write_reg(CfgQbits, 32'd15);
    write_reg(CfgCeScale, 32'h8000_0000);
    push_req(ModePacket, 4'd7, 16'd300, 6'd20);
    push_req(ModePacket, 4'd8, 16'hFFFF, 6'd40);
    push_req(ModeTick, 4'd0, 16'd0, 6'd0);
    drain();

    // Stream large packets to one port back to back, then decay it slightly.
    write_reg(CfgQbits, 32'd8);
    write_reg(CfgCeScale, 32'd1);
    write_reg(CfgDecayKeep, 32'h0000_FFFF);
    quiet = 1'b1;
    for (k = 0; k < FillPackets; k++) push_req(ModePacket, 4'd9, 16'hFFFF, 6'd63);
    drain();
    quiet = 1'b0;
    write_reg(CfgQbits, 32'd1);
    push_req(ModePacket, 4'd9, 16'd0, 6'd0);
    push_req(ModeTick, 4'd0, 16'd0, 6'd0);
    push_req(ModePacket, 4'd9, 16'hFFFF, 6'd63);
    drain();

    for (ph = 0; ph < 6; ph++) begin
      case ($urandom_range(3))
        0: rq = 32'd0;
        1: rq = 32'd1;
        2: rq = 32'd8;
        default: rq = $urandom_range(15);
      endcase
      case ($urandom_range(3))
        0: rs = 32'd0;
        1: rs = 32'hFFFF_FFFF;
        2: rs = $urandom_range(65535);
        default: rs = $urandom();
      endcase
      case ($urandom_range(3))
        0: rk = 32'd0;
        1: rk = 32'h0000_FFFF;
        2: rk = $urandom_range(65535, 49152);
        default: rk = $urandom_range(65535);
      endcase
      write_reg(CfgQbits, rq | ($urandom() << QbitsW));
      write_reg(CfgCeScale, rs);
      write_reg(CfgDecayKeep, rk | ($urandom() << KeepW));
      quiet = (ph == 2);
      for (k = 0; k < 130; k++) begin
        rp = $urandom_range(1) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
        rpay = $urandom_range(1) ? 16'($urandom()) : 16'($urandom_range(1500));
        rhdr = ($urandom_range(4) == 0) ? 6'($urandom_range(63)) :
                                          6'($urandom_range(60, 20));
        push_req(($urandom_range(99) < 6) ? ModeTick : ModePacket, rp, rpay, rhdr);
        if (ph == 1 && k == 70) drain();
      end
      drain();
    end
    quiet = 1'b0;

    $display("Covered %0d packets and %0d decay ticks over %0d register writes.",
             n_pkts, n_ticks, n_writes);
    $display("Checked %0d results, %0d mismatches.", n_results, errors);
    if (errors == 0) begin
      $display("[port_rate_estimator_quantizer_core] OK");
    end else begin
      $display("[port_rate_estimator_quantizer_core] ERROR");
    end
    $finish;
  end

endmodule
